FILE: hw/rtl/wfsc_pkg.sv
// shared constants and defaults for the windowed flow statistics counters
package wfsc_pkg;

    // parameter defaults
    localparam int DEF_CLASS_COUNT  = 32;
    localparam int DEF_COUNTER_BITS = 32;

    // field widths of one word
    localparam int CLASS_W  = 5;
    localparam int AMOUNT_W = 16;
    localparam int YEAR_W   = 16;
    localparam int TIME_W   = 32;
    localparam int TOTAL_W  = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // configuration register map
    localparam int                  APB_ADDR_W        = 3;
    localparam int                  APB_DATA_W        = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_PERIOD = 3'd0;
    localparam logic [TIME_W-1:0]   DEFAULT_PERIOD_MS  = 32'd60000;

endpackage

FILE: hw/rtl/wfsc_ram.sv
// single-port-write, single-port-read class memory with registered read data
module wfsc_ram #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 192,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/windowed_flow_statistics_counters_top.sv
// accept captures the word and reads the class memory; S_CALC registers the result
// words are taken one at a time (class memory read, then modify and write back)
// a held result stalls the write-back stage; no new word is taken while it waits
// reset: rst_n clears control, per-class flags and sets the window period to 60000 ms
// per-class flags mark stale memory entries, so no clearing pass runs after reset
module windowed_flow_statistics_counters_top import wfsc_pkg::*; #(
    parameter int CLASS_COUNT  = DEF_CLASS_COUNT,
    parameter int COUNTER_BITS = DEF_COUNTER_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0]    pwdata,
    output logic [APB_DATA_W-1:0]    prdata,
    output logic                     pready,
    // input channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [CLASS_W-1:0]       class_index,
    input  logic [AMOUNT_W-1:0]      amount,
    input  logic                     is_incoming,
    input  logic signed [YEAR_W-1:0] current_year,
    input  logic [TIME_W-1:0]        now_ms,
    // output channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [TOTAL_W-1:0]       in_year_total,
    output logic [TOTAL_W-1:0]       out_year_total,
    output logic [TOTAL_W-1:0]       in_prev_window,
    output logic [TOTAL_W-1:0]       out_prev_window,
    output logic                     year_rolled,
    output logic                     window_rolled
);

    localparam int AW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int XW = (AW > CLASS_W) ? AW : CLASS_W;
    localparam int CB = COUNTER_BITS;
    localparam int EW = 6 * CB;
    localparam int SW = ((CB > AMOUNT_W) ? CB : AMOUNT_W) + 1;
    localparam int OW = (CB > TOTAL_W) ? CB : TOTAL_W;
    localparam logic [CB-1:0] CNT_MAX = '1;

    // sequencer codes
    localparam logic S_IDLE = 1'b0;
    localparam logic S_CALC = 1'b1;

    // per-class window flag codes
    localparam logic [1:0] WS_ZERO  = 2'd0;  // window and last both zero
    localparam logic [1:0] WS_CUR   = 2'd1;  // memory window and last are current
    localparam logic [1:0] WS_SHIFT = 2'd2;  // window zero, last is memory window

    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] acc,
                                              input logic [AMOUNT_W-1:0] amt);
        logic [SW-1:0] sum;
        sum = SW'(acc) + SW'(amt);
        if (sum > SW'(CNT_MAX))
        begin
            return CNT_MAX;
        end
        return sum[CB-1:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] clip(input logic [CB-1:0] v);
        logic [OW-1:0] w;
        w = OW'(v);
        if (w > OW'(TOTAL_MAX))
        begin
            return TOTAL_MAX;
        end
        return w[TOTAL_W-1:0];
    endfunction

    // registers
    logic                state_reg, state_next;
    logic                started_reg;
    logic [YEAR_W-1:0]   stats_year_reg;
    logic [TIME_W-1:0]   win_start_reg, win_start_next;
    logic [TIME_W-1:0]   period_reg;
    logic [CLASS_W-1:0]  cls_reg;
    logic [AMOUNT_W-1:0] amt_reg;
    logic                inc_reg;
    logic [YEAR_W-1:0]   year_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [CLASS_COUNT-1:0] year_ok_reg, year_ok_next;
    logic [1:0]          wst_reg [CLASS_COUNT];
    logic [1:0]          wst_next [CLASS_COUNT];
    logic                out_valid_reg;
    logic [TOTAL_W-1:0]  in_year_reg, out_year_reg, in_prev_reg, out_prev_reg;
    logic                year_rolled_reg, window_rolled_reg;

    // datapath signals
    logic              accept;
    logic              go;
    logic              first;
    logic              year_roll;
    logic              win_roll;
    logic              cls_ok;
    logic              yr_keep;
    logic [TIME_W-1:0] start_eff;
    logic [TIME_W-1:0] elapsed;
    logic [1:0]        ws;
    logic [1:0]        ws_new;
    logic [XW-1:0]     rd_cls_x, cls_x;
    logic [AW-1:0]     rd_addr, addr;
    logic [EW-1:0]     rd_word, wr_word;
    logic [CB-1:0]     yi_e, yo_e, wi_e, wo_e, li_e, lo_e;
    logic [CB-1:0]     yi_n, yo_n, wi_n, wo_n, li_n, lo_n;
    logic              wr_en;

    // apb register access
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WINDOW_PERIOD) ? period_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= DEFAULT_PERIOD_MS;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_PERIOD))
        begin
            period_reg <= pwdata;
        end
    end

    // handshakes
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign go        = (state_reg == S_CALC) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    // memory addresses
    assign rd_cls_x = XW'(class_index);
    assign rd_addr  = rd_cls_x[AW-1:0];
    assign cls_x    = XW'(cls_reg);
    assign addr     = cls_x[AW-1:0];

    wfsc_ram #(
        .DEPTH  (CLASS_COUNT),
        .WIDTH  (EW),
        .ADDR_W (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (wr_word),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    // rollover decisions
    always_comb
    begin
        first     = !started_reg;
        year_roll = started_reg && (year_reg != stats_year_reg);
        start_eff = started_reg ? win_start_reg : now_reg;
        elapsed   = now_reg - start_eff;
        win_roll  = (elapsed >= period_reg);
        cls_ok    = (32'(cls_reg) < CLASS_COUNT);
        win_start_next = win_roll ? now_reg : start_eff;
    end

    // effective entry values from memory and flags
    always_comb
    begin
        yr_keep = cls_ok && !first && !year_roll && year_ok_reg[addr];
        ws      = (first || !cls_ok) ? WS_ZERO : wst_reg[addr];
        yi_e    = yr_keep ? rd_word[6*CB-1:5*CB] : '0;
        yo_e    = yr_keep ? rd_word[5*CB-1:4*CB] : '0;
        unique case (ws)
            WS_CUR:
            begin
                wi_e = rd_word[4*CB-1:3*CB];
                wo_e = rd_word[3*CB-1:2*CB];
                li_e = rd_word[2*CB-1:CB];
                lo_e = rd_word[CB-1:0];
            end
            WS_SHIFT:
            begin
                wi_e = '0;
                wo_e = '0;
                li_e = rd_word[4*CB-1:3*CB];
                lo_e = rd_word[3*CB-1:2*CB];
            end
            default:
            begin
                wi_e = '0;
                wo_e = '0;
                li_e = '0;
                lo_e = '0;
            end
        endcase
    end

    // saturating update and window snapshot
    always_comb
    begin
        yi_n = yi_e;
        yo_n = yo_e;
        wi_n = wi_e;
        wo_n = wo_e;
        if (inc_reg)
        begin
            yi_n = sat_add(yi_e, amt_reg);
            wi_n = sat_add(wi_e, amt_reg);
        end
        else
        begin
            yo_n = sat_add(yo_e, amt_reg);
            wo_n = sat_add(wo_e, amt_reg);
        end
        li_n    = win_roll ? wi_n : li_e;
        lo_n    = win_roll ? wo_n : lo_e;
        ws_new  = win_roll ? WS_SHIFT : WS_CUR;
        wr_word = {yi_n, yo_n, wi_n, wo_n, li_e, lo_e};
        wr_en   = go && cls_ok;
    end

    // per-class flag updates
    always_comb
    begin
        for (int j = 0; j < CLASS_COUNT; j++)
        begin
            year_ok_next[j] = (first || year_roll) ? 1'b0 : year_ok_reg[j];
            if (first)
            begin
                wst_next[j] = WS_ZERO;
            end
            else if (win_roll)
            begin
                wst_next[j] = (wst_reg[j] == WS_CUR) ? WS_SHIFT : WS_ZERO;
            end
            else
            begin
                wst_next[j] = wst_reg[j];
            end
            if (cls_ok && (32'(addr) == j))
            begin
                year_ok_next[j] = 1'b1;
                wst_next[j]     = ws_new;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            started_reg    <= 1'b0;
            stats_year_reg <= '0;
            win_start_reg  <= '0;
            year_ok_reg    <= '0;
            out_valid_reg  <= 1'b0;
            for (int j = 0; j < CLASS_COUNT; j++)
            begin
                wst_reg[j] <= WS_ZERO;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (go)
            begin
                started_reg    <= 1'b1;
                stats_year_reg <= year_reg;
                win_start_reg  <= win_start_next;
                year_ok_reg    <= year_ok_next;
                for (int j = 0; j < CLASS_COUNT; j++)
                begin
                    wst_reg[j] <= wst_next[j];
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // captured input word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cls_reg  <= class_index;
            amt_reg  <= amount;
            inc_reg  <= is_incoming;
            year_reg <= current_year;
            now_reg  <= now_ms;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            in_year_reg       <= cls_ok ? clip(yi_n) : '0;
            out_year_reg      <= cls_ok ? clip(yo_n) : '0;
            in_prev_reg       <= cls_ok ? clip(li_n) : '0;
            out_prev_reg      <= cls_ok ? clip(lo_n) : '0;
            year_rolled_reg   <= year_roll;
            window_rolled_reg <= win_roll;
        end
    end

    assign in_year_total   = in_year_reg;
    assign out_year_total  = out_year_reg;
    assign in_prev_window  = in_prev_reg;
    assign out_prev_window = out_prev_reg;
    assign year_rolled     = year_rolled_reg;
    assign window_rolled   = window_rolled_reg;

endmodule
